[rtl/tlsf_pkg.sv]
// Shared constants, codes and stage types of the TLSF class bitmap search block.
`timescale 1ns / 1ps

package tlsf_pkg;

  localparam int SL_LOG2_DEF    = 5;
  localparam int ALIGN_LOG2_DEF = 3;
  localparam int FL_MAX_DEF     = 32;

  localparam int SIZE_W    = 32;
  localparam int MODE_W    = 2;
  localparam int IDX_W     = 5;
  localparam int MIN_BLOCK = 24;

  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Operation kind after size checks; NONE gives an all-zero result.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_INSERT = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic             in_map;
    logic [IDX_W-1:0] fl;
    logic [IDX_W-1:0] sl;
  } cls_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] fl;
    logic [IDX_W-1:0] sl;
  } res_t;

endpackage

[rtl/tlsf_ram.sv]
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module tlsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 25,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[rtl/tlsf_cls.sv]
// Size to class mapping: alignment and limit checks, then class index with round-up.
`timescale 1ns / 1ps

module tlsf_cls #(
  parameter int SL_LOG2    = tlsf_pkg::SL_LOG2_DEF,
  parameter int ALIGN_LOG2 = tlsf_pkg::ALIGN_LOG2_DEF,
  parameter int FL_MAX     = tlsf_pkg::FL_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tlsf_pkg::MODE_W-1:0]   in_mode,
  input  logic [tlsf_pkg::SIZE_W-1:0]   in_size,
  output tlsf_pkg::cls_t                cls
);

  localparam int FL_SHIFT = SL_LOG2 + ALIGN_LOG2;
  localparam int FL_COUNT = FL_MAX - FL_SHIFT + 1;
  localparam int CW       = tlsf_pkg::IDX_W + SL_LOG2;
  localparam logic [32:0] ALIGN_MASK = 33'((1 << ALIGN_LOG2) - 1);

  function automatic logic [4:0] msb_idx(input logic [31:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  // stage 1: align, limit checks
  logic [32:0] a_sum, a_al;
  logic        a_big;
  logic [31:0] a_cl;
  logic [1:0]  kind1;
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [31:0] s1_val;

  always_comb begin
    a_sum = {1'b0, in_size} + ALIGN_MASK;
    a_al  = a_sum & ~ALIGN_MASK;
    a_big = |(a_al >> FL_MAX);
    a_cl  = (a_al[31:0] < 32'(tlsf_pkg::MIN_BLOCK)) ? 32'(tlsf_pkg::MIN_BLOCK) : a_al[31:0];
    case (in_mode)
      tlsf_pkg::MODE_SEARCH: begin
        kind1 = (in_size == '0 || a_big) ? tlsf_pkg::KIND_NONE : tlsf_pkg::KIND_SEARCH;
      end
      tlsf_pkg::MODE_INSERT: kind1 = tlsf_pkg::KIND_INSERT;
      tlsf_pkg::MODE_REMOVE: kind1 = tlsf_pkg::KIND_REMOVE;
      default:               kind1 = tlsf_pkg::KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_kind <= kind1;
      s1_val  <= (in_mode == tlsf_pkg::MODE_SEARCH) ? a_cl : in_size;
    end
  end

  // stage 2: class index
  logic [4:0]         m, sh, fl_raw;
  logic [31:0]        shifted, sm_shift;
  logic [SL_LOG2-1:0] sl_raw, sl_small;
  logic               is_small, rest, rnd;
  logic [CW-1:0]      cat;
  logic [tlsf_pkg::IDX_W-1:0] fl2, sl2;

  always_comb begin
    m        = msb_idx(s1_val);
    is_small = (s1_val >> FL_SHIFT) == '0;
    sh       = m - 5'(SL_LOG2);
    shifted  = s1_val >> sh;
    sl_raw   = shifted[SL_LOG2-1:0];
    fl_raw   = m - 5'(FL_SHIFT - 1);
    rest     = |(s1_val & ((32'd1 << sh) - 32'd1));
    rnd      = (s1_kind == tlsf_pkg::KIND_SEARCH) && !is_small && rest;
    cat      = {fl_raw, sl_raw} + CW'(rnd);
    sm_shift = s1_val >> ALIGN_LOG2;
    sl_small = sm_shift[SL_LOG2-1:0];
    fl2      = is_small ? '0 : cat[CW-1:SL_LOG2];
    sl2      = tlsf_pkg::IDX_W'(is_small ? sl_small : cat[SL_LOG2-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls.valid <= 1'b0;
    end else if (en) begin
      cls.valid <= s1_valid;
    end
    if (en) begin
      cls.kind   <= s1_kind;
      cls.fl     <= fl2;
      cls.sl     <= sl2;
      cls.in_map <= fl2 < 5'(FL_COUNT);
    end
  end

endmodule

[rtl/tlsf_bmp.sv]
// Occupancy bitmaps: first-level register, second-level RAM, lookup and update.
`timescale 1ns / 1ps

module tlsf_bmp #(
  parameter int SL_LOG2    = tlsf_pkg::SL_LOG2_DEF,
  parameter int ALIGN_LOG2 = tlsf_pkg::ALIGN_LOG2_DEF,
  parameter int FL_MAX     = tlsf_pkg::FL_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  tlsf_pkg::cls_t cls,
  output logic           res_valid,
  output tlsf_pkg::res_t res
);

  localparam int FL_SHIFT = SL_LOG2 + ALIGN_LOG2;
  localparam int FL_COUNT = FL_MAX - FL_SHIFT + 1;
  localparam int SL_COUNT = 1 << SL_LOG2;
  localparam int AW       = $clog2(FL_COUNT);

  function automatic logic [4:0] low_idx(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  logic [FL_COUNT-1:0] flm, flm_next;
  logic [SL_COUNT-1:0] rd_a, rd_b;

  // lookup issue stage
  logic [FL_COUNT-1:0] above, fl_cand;
  logic [4:0]          fl2_idx;
  logic [AW-1:0]       addr_a, addr_b;
  logic                live_a, live_b;

  always_comb begin
    for (int i = 0; i < FL_COUNT; i++) begin
      above[i] = tlsf_pkg::IDX_W'(i) > cls.fl;
    end
    fl_cand = flm_next & above;
    fl2_idx = low_idx(32'(fl_cand));
    addr_a  = cls.fl[AW-1:0];
    addr_b  = fl2_idx[AW-1:0];
    live_a  = cls.in_map ? flm_next[addr_a] : 1'b0;
    live_b  = (|fl_cand) ? flm_next[addr_b] : 1'b0;
  end

  tlsf_pkg::cls_t s4;
  logic [AW-1:0]  s4_addr_b;
  logic           s4_any2, s4_live_a, s4_live_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else if (en) begin
      s4.valid <= cls.valid;
    end
    if (en) begin
      s4.kind   <= cls.kind;
      s4.in_map <= cls.in_map;
      s4.fl     <= cls.fl;
      s4.sl     <= cls.sl;
      s4_addr_b <= addr_b;
      s4_any2   <= |fl_cand;
      s4_live_a <= live_a;
      s4_live_b <= live_b;
    end
  end

  // resolve stage; write of the previous transaction is forwarded
  logic                wb_valid;
  logic [AW-1:0]       wb_addr;
  logic [SL_COUNT-1:0] wb_data;
  logic [SL_COUNT-1:0] map_a, map_b, sl_bit, sl_mask, slm, new_map;
  logic [AW-1:0]       s4_addr_a;
  logic                upd, is_ins;

  always_comb begin
    s4_addr_a = s4.fl[AW-1:0];
    map_a = (wb_valid && wb_addr == s4_addr_a) ? wb_data : (rd_a & {SL_COUNT{s4_live_a}});
    map_b = (wb_valid && wb_addr == s4_addr_b) ? wb_data : (rd_b & {SL_COUNT{s4_live_b}});
    sl_bit  = {{(SL_COUNT-1){1'b0}}, 1'b1} << s4.sl[SL_LOG2-1:0];
    sl_mask = {SL_COUNT{1'b1}} << s4.sl[SL_LOG2-1:0];
    slm     = map_a & sl_mask;
    is_ins  = s4.kind == tlsf_pkg::KIND_INSERT;
    upd     = s4.valid && s4.in_map &&
              (s4.kind == tlsf_pkg::KIND_INSERT || s4.kind == tlsf_pkg::KIND_REMOVE);
    new_map = is_ins ? (map_a | sl_bit) : (map_a & ~sl_bit);
    flm_next = flm;
    if (upd) begin
      if (is_ins) begin
        flm_next[s4_addr_a] = 1'b1;
      end else if (new_map == '0) begin
        flm_next[s4_addr_a] = 1'b0;
      end
    end
    res = '0;
    case (s4.kind)
      tlsf_pkg::KIND_SEARCH: begin
        if (s4.in_map) begin
          if (slm != '0) begin
            res.found = 1'b1;
            res.fl    = s4.fl;
            res.sl    = low_idx(32'(slm));
          end else if (s4_any2 && map_b != '0) begin
            res.found = 1'b1;
            res.fl    = tlsf_pkg::IDX_W'(s4_addr_b);
            res.sl    = low_idx(32'(map_b));
          end
        end
      end
      tlsf_pkg::KIND_INSERT, tlsf_pkg::KIND_REMOVE: begin
        res.fl = s4.fl;
        res.sl = s4.sl;
      end
      default: res = '0;
    endcase
  end

  assign res_valid = s4.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      flm      <= '0;
      wb_valid <= 1'b0;
    end else if (en) begin
      flm      <= flm_next;
      wb_valid <= upd;
    end
    if (en) begin
      wb_addr <= s4_addr_a;
      wb_data <= new_map;
    end
  end

  tlsf_ram #(
    .WIDTH(SL_COUNT),
    .DEPTH(FL_COUNT)
  ) u_sl_ram (
    .clk      (clk),
    .wr_en    (en && upd),
    .wr_addr  (s4_addr_a),
    .wr_data  (new_map),
    .rd_en    (en),
    .rd_addr_a(addr_a),
    .rd_addr_b(addr_b),
    .rd_data_a(rd_a),
    .rd_data_b(rd_b)
  );

  // first-level bit tracks whether the last written row is nonempty
  a_wb_flm: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> (flm[wb_addr] == (wb_data != '0)))
    else $error("first-level bit disagrees with written second-level row");

  a_found_nonempty: assert property (@(posedge clk) disable iff (rst)
    (s4.valid && res.found) |-> flm[res.fl[AW-1:0]])
    else $error("search hit on a class marked empty");

  a_found_search: assert property (@(posedge clk) disable iff (rst)
    (s4.valid && res.found) |-> (s4.kind == tlsf_pkg::KIND_SEARCH))
    else $error("found set outside search");

endmodule

[rtl/tlsf_class_bitmap_search.sv]
// Top level of the TLSF class bitmap search block: stream ports, input and output registers.
`timescale 1ns / 1ps

// TLSF two-level occupancy bitmaps with class lookup. Each input transaction
// carries a mode (search, insert, remove) and a size; each one yields exactly
// one result transaction with found, first and second class index. One
// transaction is accepted per cycle while the output side keeps up; a result
// passes through the input register, two class-mapping stages and the
// second-level RAM read, then the resolve stage loads the output register.
// A result waiting on the output freezes every stage, so the input stalls
// once the input register is occupied. The second-level RAM takes one update
// per cycle while the pipeline advances, with the previous update forwarded
// to the next lookup. The bitmaps read as empty right after reset:
// a second-level row counts only while its first-level bit is set, so no
// clearing pass is needed.
module tlsf_class_bitmap_search #(
  parameter int SL_LOG2    = tlsf_pkg::SL_LOG2_DEF,
  parameter int ALIGN_LOG2 = tlsf_pkg::ALIGN_LOG2_DEF,
  parameter int FL_MAX     = tlsf_pkg::FL_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] size
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [4:0] first_index, [9:5] second_index, rest zero
  output logic        m_axis_tuser    // [0] found
);

  logic                        adv, p0_load;
  logic                        p0_valid;
  logic [tlsf_pkg::MODE_W-1:0] p0_mode;
  logic [tlsf_pkg::SIZE_W-1:0] p0_size;
  tlsf_pkg::cls_t              cls;
  tlsf_pkg::res_t              res, out_res;
  logic                        res_valid;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign p0_load       = adv || !p0_valid;
  assign s_axis_tready = p0_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (p0_load) begin
      p0_valid <= s_axis_tvalid;
    end
    if (p0_load) begin
      p0_mode <= s_axis_tuser;
      p0_size <= s_axis_tdata;
    end
  end

  tlsf_cls #(
    .SL_LOG2   (SL_LOG2),
    .ALIGN_LOG2(ALIGN_LOG2),
    .FL_MAX    (FL_MAX)
  ) u_cls (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_valid(p0_valid),
    .in_mode (p0_mode),
    .in_size (p0_size),
    .cls     (cls)
  );

  tlsf_bmp #(
    .SL_LOG2   (SL_LOG2),
    .ALIGN_LOG2(ALIGN_LOG2),
    .FL_MAX    (FL_MAX)
  ) u_bmp (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .cls      (cls),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= res_valid;
    end
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_res.sl, out_res.fl};
  assign m_axis_tuser = out_res.found;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule
